/* rtl/dtbp_pkg.sv */
// Shared types and constants of the dual token bucket policer.
// No dependencies; the mac, sequencer and top level import this package.
package dtbp_pkg;

   localparam int TS_W    = 64;   // timestamp width
   localparam int LEN_W   = 20;   // packet length width
   localparam int LIMIT_W = 32;   // kbps register width
   localparam int TOK_W   = 40;   // bucket depth, never above 250 * (2^32 - 1)
   localparam int SUM_W   = 41;   // bucket plus refill before the cap
   localparam int ELAP_W  = 20;   // whole microseconds, at most one million
   localparam int X_W     = 27;   // nanoseconds / 8 below one second
   localparam int Y_W     = 46;   // (limit * elapsed) / 64
   localparam int HALF_W  = 24;   // partial product split point
   localparam int MUL_W   = 32;   // shared multiplier operand width
   localparam int ACC_W   = 64;   // shared accumulator width

   localparam logic [TS_W-1:0]   NS_CAP      = 64'd1_000_000_000;
   localparam logic [ELAP_W-1:0] ELAPSED_CAP = 20'd1_000_000;

   // ceil(2^34 / 125): exact quotient for 27-bit dividends
   localparam logic [MUL_W-1:0] RECIP_125_SHORT =
      32'(((64'd1 << 34) + 64'd124) / 64'd125);
   // ceil(2^53 / 125): exact quotient for 46-bit dividends
   localparam logic [46:0] RECIP_125_LONG =
      47'(((64'd1 << 53) + 64'd124) / 64'd125);
   localparam logic [MUL_W-1:0] RECIP_LO = 32'(RECIP_125_LONG[23:0]);
   localparam logic [MUL_W-1:0] RECIP_HI = 32'(RECIP_125_LONG[46:24]);
   localparam logic [MUL_W-1:0] CAP_MULT = 32'd250;   // 2 * 125 bytes per kbit

   // operand A select codes
   localparam logic [2:0] A_DIFF  = 3'd0;
   localparam logic [2:0] A_LIMIT = 3'd1;
   localparam logic [2:0] A_PLO   = 3'd2;
   localparam logic [2:0] A_YLO   = 3'd3;
   localparam logic [2:0] A_YHI   = 3'd4;

   // operand B select codes
   localparam logic [2:0] B_RSHORT  = 3'd0;
   localparam logic [2:0] B_ELAPSED = 3'd1;
   localparam logic [2:0] B_RLO     = 3'd2;
   localparam logic [2:0] B_RHI     = 3'd3;
   localparam logic [2:0] B_CAPK    = 3'd4;

   typedef struct packed {
      logic en;      // update accumulator
      logic clear;   // start from zero
      logic shift;   // drop the low 24 bits of the accumulator first
   } mac_op_type;

   typedef struct packed {
      mac_op_type op;
      logic [2:0] a_sel;
      logic [2:0] b_sel;
      logic       ld_diff;
      logic       ld_y;
      logic       ld_sum;
      logic       ld_tokens;
      logic       finish;
   } ctrl_type;

endpackage

/* rtl/dtbp_mac.sv */
// Shared multiply-accumulate unit of the policer.
// Depends on dtbp_pkg.
module dtbp_mac (
   input  logic                           clock,
   input  dtbp_pkg::mac_op_type           op,
   input  logic [dtbp_pkg::MUL_W-1:0]     a,
   input  logic [dtbp_pkg::MUL_W-1:0]     b,
   output logic [dtbp_pkg::ACC_W-1:0]     acc
);
   import dtbp_pkg::*;

   logic [ACC_W-1:0] acc_ff;
   logic [ACC_W-1:0] acc_in;
   logic [ACC_W-1:0] base;

   always_comb begin
      priority if (op.clear) begin
         base = '0;
      end else if (op.shift) begin
         base = acc_ff >> HALF_W;
      end else begin
         base = acc_ff;
      end
      acc_in = base + (ACC_W'(a) * ACC_W'(b));
   end

   always_ff @(posedge clock) begin
      if (op.en) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

/* rtl/dtbp_seq.sv */
// Step sequencer of the policer: walks one request through the shared unit.
// Depends on dtbp_pkg.
module dtbp_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               bypass,
   input  logic               out_free,
   output logic               ready,
   output dtbp_pkg::ctrl_type ctrl
);
   import dtbp_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_DIFF = 4'd1;
   localparam logic [3:0] ST_ELAP = 4'd2;
   localparam logic [3:0] ST_PROD = 4'd3;
   localparam logic [3:0] ST_PLL  = 4'd4;
   localparam logic [3:0] ST_PLH  = 4'd5;
   localparam logic [3:0] ST_PHL  = 4'd6;
   localparam logic [3:0] ST_PHH  = 4'd7;
   localparam logic [3:0] ST_CAP  = 4'd8;
   localparam logic [3:0] ST_TOKS = 4'd9;
   localparam logic [3:0] ST_DONE = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = bypass ? ST_DONE : ST_DIFF;
            end
         end
         ST_DIFF: begin
            ctrl.ld_diff = 1'b1;
            state_in     = ST_ELAP;
         end
         ST_ELAP: begin
            ctrl.op    = '{en: 1'b1, clear: 1'b1, shift: 1'b0};
            ctrl.a_sel = A_DIFF;
            ctrl.b_sel = B_RSHORT;
            state_in   = ST_PROD;
         end
         ST_PROD: begin
            ctrl.op    = '{en: 1'b1, clear: 1'b1, shift: 1'b0};
            ctrl.a_sel = A_LIMIT;
            ctrl.b_sel = B_ELAPSED;
            state_in   = ST_PLL;
         end
         ST_PLL: begin
            ctrl.op    = '{en: 1'b1, clear: 1'b1, shift: 1'b0};
            ctrl.a_sel = A_PLO;
            ctrl.b_sel = B_RLO;
            ctrl.ld_y  = 1'b1;
            state_in   = ST_PLH;
         end
         ST_PLH: begin
            ctrl.op    = '{en: 1'b1, clear: 1'b0, shift: 1'b1};
            ctrl.a_sel = A_YLO;
            ctrl.b_sel = B_RHI;
            state_in   = ST_PHL;
         end
         ST_PHL: begin
            ctrl.op    = '{en: 1'b1, clear: 1'b0, shift: 1'b0};
            ctrl.a_sel = A_YHI;
            ctrl.b_sel = B_RLO;
            state_in   = ST_PHH;
         end
         ST_PHH: begin
            ctrl.op    = '{en: 1'b1, clear: 1'b0, shift: 1'b1};
            ctrl.a_sel = A_YHI;
            ctrl.b_sel = B_RHI;
            state_in   = ST_CAP;
         end
         ST_CAP: begin
            ctrl.op     = '{en: 1'b1, clear: 1'b1, shift: 1'b0};
            ctrl.a_sel  = A_LIMIT;
            ctrl.b_sel  = B_CAPK;
            ctrl.ld_sum = 1'b1;
            state_in    = ST_TOKS;
         end
         ST_TOKS: begin
            ctrl.ld_tokens = 1'b1;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               ctrl.finish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign ready = (state_ff == ST_IDLE);

endmodule

/* rtl/dual_token_bucket_policer.sv */
// Top level of the dual token bucket policer: handshakes, bucket state, datapath.
// Depends on dtbp_pkg, dtbp_mac and dtbp_seq.
//
//   channel  ports      direction  contents
//   request  req_*      in         tuser: direction; tdata: timestamp_ns, packet_length
//   response rsp_*      out        tdata: allow
//   config   csr_*      in         index 0 upload limit, 1 download limit
//
// A request is worked on one step at a time from acceptance to the response
// register, and the next request is taken only once the sequencer is idle again:
// the shared 32x32 multiply-accumulate unit runs seven products in a row (elapsed
// microseconds, limit times elapsed, four partial products of the divide by
// 8000, the bucket cap) plus subtract, refill and decide steps. A request whose
// direction has no bucket skips straight from acceptance to the decide step.
// Reset is synchronous and clears the limits, both buckets and both last-seen
// times. The next request is taken while a response waits; a stalled response
// stops the sequencer only at its last step.
module dual_token_bucket_policer #(
   parameter int NUM_DIRECTIONS = 2
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,    // [63:0] timestamp_ns, [83:64] packet_length, rest zero
   input  logic        req_tuser,    // [0] direction
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [0] allow, rest zero
   // configuration writes
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [31:0] csr_wdata
);
   import dtbp_pkg::*;

   localparam logic CSR_UPLOAD   = 1'b0;
   localparam logic CSR_DOWNLOAD = 1'b1;

   // configuration
   logic [LIMIT_W-1:0] up_limit_ff;
   logic [LIMIT_W-1:0] down_limit_ff;

   // bucket state, one entry per direction
   logic [TOK_W-1:0] tok_ff  [NUM_DIRECTIONS];
   logic [TS_W-1:0]  last_ff [NUM_DIRECTIONS];

   // request being worked on
   logic             dir_ff;
   logic             bypass_ff;
   logic [TS_W-1:0]  now_ff;
   logic [LEN_W-1:0] len_ff;

   // intermediate results
   logic             big_ff;
   logic [X_W-1:0]   x_ff;
   logic [Y_W-1:0]   y_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [TOK_W-1:0] tokens_ff;

   // response register
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic allow_ff;

   logic               req_accept;
   logic               req_bypass;
   logic               seq_ready;
   ctrl_type           ctrl;
   logic [ACC_W-1:0]   acc;
   logic [MUL_W-1:0]   mac_a;
   logic [MUL_W-1:0]   mac_b;
   logic [LIMIT_W-1:0] limit_sel;
   logic [TOK_W-1:0]   tok_sel;
   logic [TS_W-1:0]    last_sel;
   logic [TS_W-1:0]    diff;
   logic [ELAP_W-1:0]  elapsed;
   logic [SUM_W-1:0]   cap;
   logic               allow;
   logic [TOK_W-1:0]   tok_next;

   assign req_accept = req_tvalid && req_tready;
   assign req_bypass = int'(req_tuser) >= NUM_DIRECTIONS;

   // configuration write port
   always_ff @(posedge clock) begin
      if (reset) begin
         up_limit_ff   <= '0;
         down_limit_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_UPLOAD:   up_limit_ff   <= csr_wdata;
            CSR_DOWNLOAD: down_limit_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   dtbp_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .bypass   (req_bypass),
      .out_free (!rsp_valid_ff || rsp_tready),
      .ready    (seq_ready),
      .ctrl     (ctrl)
   );

   assign req_tready = seq_ready;

   // latch the request
   always_ff @(posedge clock) begin
      if (req_accept) begin
         dir_ff    <= req_tuser;
         bypass_ff <= req_bypass;
         now_ff    <= req_tdata[TS_W-1:0];
         len_ff    <= req_tdata[TS_W+LEN_W-1:TS_W];
      end
   end

   // select this direction's limit and bucket
   assign limit_sel = dir_ff ? down_limit_ff : up_limit_ff;

   always_comb begin
      tok_sel  = '0;
      last_sel = '0;
      for (int i = 0; i < NUM_DIRECTIONS; i++) begin
         if (dir_ff == 1'(i)) begin
            tok_sel  = tok_ff[i];
            last_sel = last_ff[i];
         end
      end
   end

   // wrapping time difference; anything from one second up caps the refill
   assign diff = now_ff - last_sel;

   always_ff @(posedge clock) begin
      if (ctrl.ld_diff) begin
         big_ff <= diff >= NS_CAP;
         x_ff   <= diff[X_W+2:3];
      end
   end

   // elapsed microseconds: (ns / 8) / 125 by reciprocal, or the one-second cap
   assign elapsed = big_ff ? ELAPSED_CAP : acc[34+ELAP_W-1:34];

   // operand selection for the shared unit
   always_comb begin
      unique case (ctrl.a_sel)
         A_DIFF:  mac_a = MUL_W'(x_ff);
         A_LIMIT: mac_a = limit_sel;
         A_PLO:   mac_a = MUL_W'(acc[HALF_W+5:6]);
         A_YLO:   mac_a = MUL_W'(y_ff[HALF_W-1:0]);
         A_YHI:   mac_a = MUL_W'(y_ff[Y_W-1:HALF_W]);
         default: mac_a = '0;
      endcase
      unique case (ctrl.b_sel)
         B_RSHORT:  mac_b = RECIP_125_SHORT;
         B_ELAPSED: mac_b = MUL_W'(elapsed);
         B_RLO:     mac_b = RECIP_LO;
         B_RHI:     mac_b = RECIP_HI;
         B_CAPK:    mac_b = CAP_MULT;
         default:   mac_b = '0;
      endcase
   end

   dtbp_mac u_mac (
      .clock (clock),
      .op    (ctrl.op),
      .a     (mac_a),
      .b     (mac_b),
      .acc   (acc)
   );

   // refill = (limit * elapsed) / 8000: hold (product / 64), then divide by 125
   // through four partial products; the refill lands in acc from bit 5 up
   always_ff @(posedge clock) begin
      if (ctrl.ld_y) begin
         y_ff <= acc[Y_W+5:6];
      end
      if (ctrl.ld_sum) begin
         sum_ff <= SUM_W'(tok_sel) + SUM_W'(acc[TOK_W+4:5]);
      end
      if (ctrl.ld_tokens) begin
         tokens_ff <= (sum_ff < cap) ? TOK_W'(sum_ff) : TOK_W'(cap);
      end
   end

   // cap = limit * 250, just computed by the shared unit
   assign cap = acc[SUM_W-1:0];

   // verdict: pass when the bucket covers the length, then take it away
   assign allow    = bypass_ff || (tokens_ff >= TOK_W'(len_ff));
   assign tok_next = allow ? (tokens_ff - TOK_W'(len_ff)) : tokens_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DIRECTIONS; i++) begin
            tok_ff[i]  <= '0;
            last_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < NUM_DIRECTIONS; i++) begin
            if (dir_ff == 1'(i)) begin
               if (ctrl.ld_diff) begin
                  last_ff[i] <= now_ff;
               end
               if (ctrl.finish && !bypass_ff) begin
                  tok_ff[i] <= tok_next;
               end
            end
         end
      end
   end

   // response register: load on finish, drop once taken, else hold
   always_comb begin
      priority if (ctrl.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         allow_ff <= allow;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, allow_ff};

endmodule

/* rtl/dtbp_checker.sv */
// Port-level checks of the dual token bucket policer, bound to the top level.
// Depends on dual_token_bucket_policer.
module dtbp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // one request at a time: busy right after taking one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a previous one is in work");

   // idle and empty right after reset
   a_clean_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (req_tready && !rsp_tvalid))
      else $error("not idle after reset");

   // a new response appears only at the end of a request's work
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response appeared without a request in work");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind dual_token_bucket_policer dtbp_checker u_dtbp_checker (.*);

/* tb/dual_token_bucket_policer_tb.sv */
// Self-checking testbench for the dual token bucket policer: directed and random
// packets checked against a bucket predictor. Depends on dtbp_pkg and the rtl.
`timescale 1ns / 100ps

module dual_token_bucket_policer_tb;
   import dtbp_pkg::*;

   localparam bit   DIR_UPLOAD         = 1'b0;
   localparam bit   DIR_DOWNLOAD       = 1'b1;
   localparam bit   REG_UPLOAD_LIMIT   = 1'b0;
   localparam bit   REG_DOWNLOAD_LIMIT = 1'b1;
   localparam logic [31:0] LIMIT_MAX   = 32'hFFFF_FFFF;
   localparam logic [19:0] LEN_MAX     = 20'hF_FFFF;
   localparam logic [63:0] TS_MAX      = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] USEC_CAP    = 64'd1_000_000;
   // room for a pass through the datapath plus margin before touching the limits
   localparam int   SETTLE_CYCLES      = 20;
   localparam int   RANDOM_PER_PHASE   = 130;

   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_STALL, IDLE_BOTH} idle_mode_type;

   typedef struct {
      bit          allow;
      int unsigned seq;
      bit          dir;
      logic [19:0] len;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;   // [63:0] timestamp_ns, [83:64] packet_length
   logic        req_tuser = 1'b0; // [0] direction
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [0] allow
   logic        csr_we = 1'b0;
   logic        csr_addr = 1'b0;
   logic [31:0] csr_wdata = '0;

   // predictor copy of the limits and both buckets
   logic [31:0] limit_reg [2];
   logic [63:0] bucket_tokens [2];
   logic [63:0] bucket_stamp [2];

   verdict_type verdict_q [$];
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int unsigned n_sent = 0;
   int unsigned n_checked = 0;
   int unsigned n_allowed = 0;
   int unsigned n_dropped = 0;
   int unsigned n_errors = 0;

   dual_token_bucket_policer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Refill the bucket of one direction for the time since its last packet, then
   // pass the packet if the bucket covers its length. The bucket is capped at two
   // seconds worth of tokens; elapsed time is capped at one second.
   function automatic bit police_packet(bit dir, logic [63:0] ts, logic [19:0] len);
      logic [63:0] rate;
      logic [63:0] elapsed;
      logic [63:0] tokens;
      rate    = 64'(limit_reg[dir]) * 64'd125;
      // wraps modulo 2^64 when the timestamp goes backwards
      elapsed = (ts - bucket_stamp[dir]) / 64'd1000;
      if (elapsed > USEC_CAP)
         elapsed = USEC_CAP;
      tokens = bucket_tokens[dir] + (rate * elapsed) / USEC_CAP;
      bucket_stamp[dir] = ts;
      if (tokens > rate * 64'd2)
         tokens = rate * 64'd2;
      if (tokens >= 64'(len)) begin
         bucket_tokens[dir] = tokens - 64'(len);
         return 1'b1;
      end
      bucket_tokens[dir] = tokens;
      return 1'b0;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      n_errors++;
   endtask

   function automatic void set_idling(idle_mode_type mode);
      send_idle_pct = (mode == IDLE_SEND) ? 52 : (mode == IDLE_BOTH) ? 17 : 0;
      stall_pct     = (mode == IDLE_STALL) ? 52 : (mode == IDLE_BOTH) ? 17 : 0;
   endfunction

   // Write one limit register; the block must be idle. Drops the write strobe again before returning.
   task automatic write_limit(input bit index, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      limit_reg[index] = value;
      @(posedge clock);
   endtask

   // Send one request and hold it until accepted. Record the expected verdict at
   // the accepting edge, so the predictor sees requests in acceptance order.
   task automatic send_request(input bit dir, input logic [63:0] ts,
                               input logic [19:0] len);
      verdict_type v;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= dir;
      req_tdata  <= {4'b0, len, ts};
      do
         @(posedge clock);
      while (!req_tready);
      v.allow = police_packet(dir, ts, len);
      v.seq   = n_sent;
      v.dir   = dir;
      v.len   = len;
      verdict_q.push_back(v);
      n_sent++;
   endtask

   // Drop valid, wait for every outstanding verdict, then let the pipe settle.
   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      while (verdict_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver backpressure, redrawn every cycle
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   // response checker: each accepted response against the oldest expectation
   always @(posedge clock) begin
      verdict_type v;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_q.size() == 0) begin
            report_mismatch($sformatf("response allow=%0b with no request pending",
                                      rsp_tdata[0]));
         end else begin
            v = verdict_q.pop_front();
            n_checked++;
            if (v.allow)
               n_allowed++;
            else
               n_dropped++;
            if (rsp_tdata[0] !== v.allow)
               report_mismatch($sformatf("request %0d dir=%0b len=%0d: allow=%b, want %0b",
                                         v.seq, v.dir, v.len, rsp_tdata[0], v.allow));
         end
      end
   end

   // Zero limits after reset: buckets are capped at nothing, so only empty
   // packets pass. Covers the first packet after reset in both directions.
   task automatic test_zero_limits();
      set_idling(IDLE_NONE);
      write_limit(REG_UPLOAD_LIMIT, 32'd0);
      write_limit(REG_DOWNLOAD_LIMIT, 32'd0);
      send_request(DIR_UPLOAD, 64'd0, 20'd0);
      send_request(DIR_DOWNLOAD, 64'd1_000, 20'd1);
      send_request(DIR_DOWNLOAD, 64'd2_000, 20'd0);
      send_request(DIR_UPLOAD, 64'd3_000_000_000, LEN_MAX);
      wait_for_quiet();
   endtask

   // Extreme limits and timestamps, refill arithmetic, cap at two seconds of
   // tokens, and a timestamp going backwards.
   task automatic test_extremes();
      set_idling(IDLE_NONE);
      write_limit(REG_UPLOAD_LIMIT, LIMIT_MAX);
      write_limit(REG_DOWNLOAD_LIMIT, 32'd8);              // 1000 bytes per second
      send_request(DIR_UPLOAD, TS_MAX, LEN_MAX);
      send_request(DIR_UPLOAD, TS_MAX, LEN_MAX);
      send_request(DIR_UPLOAD, 64'd0, 20'd1);              // wraps to one nanosecond
      send_request(DIR_DOWNLOAD, 64'd1_000_002_000, 20'd1000);
      send_request(DIR_DOWNLOAD, 64'd1_000_003_000, 20'd1);
      send_request(DIR_DOWNLOAD, 64'd4_000_003_000, 20'd2000);
      send_request(DIR_DOWNLOAD, 64'd5_000_003_000, 20'd2000);
      send_request(DIR_DOWNLOAD, 64'd5, 20'd1000);         // backwards in time
      send_request(DIR_DOWNLOAD, 64'd5, 20'd1);
      wait_for_quiet();
   endtask

   // Limit dropped while the bucket is full: the excess is cut at the next packet.
   task automatic test_limit_change();
      set_idling(IDLE_NONE);
      write_limit(REG_DOWNLOAD_LIMIT, LIMIT_MAX);
      send_request(DIR_DOWNLOAD, 64'd2_000_000_005, LEN_MAX);
      send_request(DIR_DOWNLOAD, 64'd4_000_000_005, 20'd1);
      wait_for_quiet();
      write_limit(REG_DOWNLOAD_LIMIT, 32'd1);              // cap falls to 250 bytes
      send_request(DIR_DOWNLOAD, 64'd4_000_001_005, 20'd251);
      send_request(DIR_DOWNLOAD, 64'd4_000_001_005, 20'd250);
      send_request(DIR_DOWNLOAD, 64'd4_000_002_005, 20'd1);
      wait_for_quiet();
   endtask

   function automatic logic [31:0] pick_limit(int phase, bit dir);
      int pick;
      // pin the extremes in phases 0 and 2, else draw from rate classes
      if (phase == 0)
         return dir ? 32'd0 : LIMIT_MAX;
      if (phase == 2)
         return dir ? LIMIT_MAX : 32'd0;
      pick = $urandom_range(9);
      if (pick == 0)
         return 32'd0;
      if (pick <= 3)
         return $urandom_range(1, 100);
      if (pick <= 7)
         return $urandom_range(100, 100_000);
      if (pick == 8)
         return $urandom;
      return LIMIT_MAX;
   endfunction

   // Random traffic: per-direction clocks that mostly advance by realistic gaps,
   // with long silences, backward jumps and arbitrary timestamps mixed in.
   task automatic test_random_traffic();
      logic [63:0] wall_ns [2];
      logic [63:0] ts;
      logic [19:0] len;
      bit          dir;
      int          pick;
      wall_ns[0] = 64'({$urandom, $urandom} >> 8);
      wall_ns[1] = wall_ns[0];
      for (int phase = 0; phase < 8; phase++) begin
         write_limit(REG_UPLOAD_LIMIT, pick_limit(phase, DIR_UPLOAD));
         write_limit(REG_DOWNLOAD_LIMIT, pick_limit(phase, DIR_DOWNLOAD));
         set_idling(idle_mode_type'(phase % 4));
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            dir  = 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 45)
               wall_ns[dir] = wall_ns[dir] + $urandom_range(0, 2_000_000);
            else if (pick < 70)
               wall_ns[dir] = wall_ns[dir] + $urandom_range(0, 5_000);
            else if (pick < 85)
               wall_ns[dir] = wall_ns[dir] + $urandom_range(0, 2_100_000_000);
            else if (pick < 92)
               wall_ns[dir] = wall_ns[dir] - $urandom_range(1, 1_000_000_000);
            else
               wall_ns[dir] = {$urandom, $urandom};
            ts   = wall_ns[dir];
            pick = $urandom_range(99);
            if (pick < 60)
               len = 20'($urandom_range(0, 1600));
            else if (pick < 80)
               len = 20'($urandom_range(0, 65535));
            else if (pick < 95)
               len = 20'($urandom_range(0, 1_048_575));
            else
               len = $urandom_range(1) ? LEN_MAX : 20'd0;
            send_request(dir, ts, len);
         end
         // hold the sender until the block has drained before the next setting
         wait_for_quiet();
      end
   endtask

   initial begin
      limit_reg[0]     = '0;
      limit_reg[1]     = '0;
      bucket_tokens[0] = '0;
      bucket_tokens[1] = '0;
      bucket_stamp[0]  = '0;
      bucket_stamp[1]  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_zero_limits();
      test_extremes();
      test_limit_change();
      test_random_traffic();

      $display("Covered %0d requests, zero to full-scale limits: %0d passed, %0d dropped.",
               n_sent, n_allowed, n_dropped);
      $display("Checked %0d verdicts under four idling and backpressure modes, %0d mismatches.",
               n_checked, n_errors);
      if (n_errors == 0)
         $display("dual_token_bucket_policer_tb: PASS");
      else
         $display("dual_token_bucket_policer_tb: FAIL");
      $finish;
   end

   // Watchdog: allow 10 ms for the whole run.
   initial begin
      #10_000_000;
      $display("dual_token_bucket_policer_tb: FAIL");
      $finish;
   end

endmodule

/* files.f */
rtl/dtbp_pkg.sv
rtl/dtbp_mac.sv
rtl/dtbp_seq.sv
rtl/dual_token_bucket_policer.sv
rtl/dtbp_checker.sv
tb/dual_token_bucket_policer_tb.sv
